[hw/rtl/fplf_pkg.sv]
// Shared types, widths and helpers of the four-pole ladder filter.
`timescale 1ns / 1ps

package fplf_pkg;

  // Sample, coefficient and state formats
  localparam int SAMPLE_BITS = 24;                 // Q1.23
  localparam int COEF_BITS   = 32;                 // Q5.27
  localparam int STATE_BITS  = SAMPLE_BITS + 8;    // Q9.23
  localparam int FRAC_C      = COEF_BITS - 5;
  localparam int PROD_BITS   = COEF_BITS + STATE_BITS;
  localparam int RND_BITS    = PROD_BITS - FRAC_C;
  localparam int SUM_BITS    = RND_BITS + 2;
  localparam int NUM_STAGES  = 4;
  localparam int NUM_CELLS   = NUM_STAGES + 1;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [RND_BITS-1:0]    rnd_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_DRIVE = 3'd0,
    REG_DC    = 3'd1,
    REG_FBK   = 3'd2,
    REG_GAIN  = 3'd3,
    REG_POLE  = 3'd4
  } reg_idx_e;

  // Cell sequencer
  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_SECOND,
    CELL_SUM
  } cell_state_e;

  // Status a cell hands to the control
  typedef struct packed {
    logic done;
    logic clip;
  } cell_stat_t;

  // Round a coefficient product to the state fraction, half up
  function automatic rnd_t round_prod(prod_t p);
    prod_t t;
    t = p + (prod_t'(1) <<< (FRAC_C - 1));
    return rnd_t'(t[PROD_BITS-1:FRAC_C]);
  endfunction

endpackage

[hw/rtl/fplf_if.sv]
// Stream interfaces for filter input and result words.
`timescale 1ns / 1ps

interface fplf_in_if;
  logic              valid;
  logic              ready;
  fplf_pkg::sample_t sample_in;

  modport source(output valid, output sample_in, input ready);
  modport sink(input valid, input sample_in, output ready);
endinterface

interface fplf_out_if;
  logic              valid;
  logic              ready;
  fplf_pkg::sample_t sample_out;
  logic              clipped;

  modport source(output valid, output sample_out, output clipped, input ready);
  modport sink(input valid, input sample_out, input clipped, output ready);
endinterface

[hw/rtl/four_pole_ladder_filter.sv]
// Top level of the four-pole ladder filter: control, registers and the row of cells.
`timescale 1ns / 1ps

// Four-pole ladder filter, one mono channel. Each accepted word runs through a row
// of five identical cells: the first forms drive*in - k*feedback + offset, the next
// four are the one-pole sections, each holding its own state. A cell shares one
// 32x32 multiplier over its phases and starts its right neighbor in its last phase,
// so neighbors overlap in that phase. A word runs through the head cell, then each
// section in turn, and its result is loaded into the output register once that is
// free; the next word is accepted in the cycle after that load, so no new word
// enters while the cells still hold one. A result may wait in the output register
// while the next word is already being worked on; a second finished result waits in
// the last cell and blocks the input. Registers sit on an APB port at byte addresses
// 0, 4, 8, 12 and 16: drive gain, dc offset, feedback gain, stage gain and stage
// pole; write them only while the filter is idle.

module four_pole_ladder_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fplf_in_if.sink                      in_if,
  fplf_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fplf_pkg::ADDR_BITS-1:0] paddr,
  input  logic [fplf_pkg::DATA_BITS-1:0] pwdata,
  output logic [fplf_pkg::DATA_BITS-1:0] prdata,
  output logic                         pready
);
  import fplf_pkg::*;

  // Configuration registers
  logic [COEF_BITS-2:0] drive_q;
  sample_t              dc_q;
  coef_t                fbk_q, gain_q, pole_q;
  logic                 wr_en;

  // Control
  logic    busy_q, go_q, pend_q, clip_q, last_done_q;
  sample_t sample_q;
  logic    out_valid_q, out_clip_q;
  sample_t out_sample_q;

  // Cell row
  logic       [NUM_CELLS-1:0] go;
  coef_t      c1 [NUM_CELLS];
  coef_t      c2 [NUM_CELLS];
  state_t     u  [NUM_CELLS];
  state_t     v  [NUM_CELLS];
  state_t     off[NUM_CELLS];
  state_t     y  [NUM_CELLS];
  cell_stat_t stat[NUM_CELLS];
  logic       [NUM_CELLS-1:0] clip_vec;

  logic    accept, have_result, load;
  logic    clip_now, out_ovf;
  state_t  y_last;
  sample_t sat_out;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= (COEF_BITS-1)'(1) << FRAC_C;
      dc_q    <= '0;
      fbk_q   <= '0;
      gain_q  <= coef_t'(1) <<< FRAC_C;
      pole_q  <= '0;
    end else if (wr_en) begin
      case (paddr[ADDR_BITS-1:2])
        REG_DRIVE: drive_q <= pwdata[COEF_BITS-2:0];
        REG_DC:    dc_q    <= pwdata[SAMPLE_BITS-1:0];
        REG_FBK:   fbk_q   <= pwdata[COEF_BITS-1:0];
        REG_GAIN:  gain_q  <= pwdata[COEF_BITS-1:0];
        REG_POLE:  pole_q  <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration
  always_comb begin
    case (paddr[ADDR_BITS-1:2])
      REG_DRIVE: prdata = DATA_BITS'(drive_q);
      REG_DC:    prdata = DATA_BITS'(dc_q);
      REG_FBK:   prdata = DATA_BITS'(fbk_q);
      REG_GAIN:  prdata = DATA_BITS'(gain_q);
      REG_POLE:  prdata = DATA_BITS'(pole_q);
      default:   prdata = '0;
    endcase
  end

  // Wire up the row: head cell first, then the four sections
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign go[k]  = go_q;
      assign c1[k]  = coef_t'({1'b0, drive_q});
      assign u[k]   = state_t'(sample_q);
      assign c2[k]  = fbk_q;
      assign v[k]   = y[NUM_CELLS-1];
      assign off[k] = state_t'(dc_q);
    end else begin : g_sec
      assign go[k]  = stat[k-1].done;
      assign c1[k]  = gain_q;
      assign u[k]   = y[k-1];
      assign c2[k]  = pole_q;
      assign v[k]   = y[k];
      assign off[k] = '0;
    end

    fplf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .go_i   (go[k]),
      .c1_i   (c1[k]),
      .u_i    (u[k]),
      .c2_i   (c2[k]),
      .v_i    (v[k]),
      .off_i  (off[k]),
      .y_o    (y[k]),
      .stat_o (stat[k])
    );

    assign clip_vec[k] = stat[k].done && stat[k].clip;
  end

  // Saturate the last section to the sample range
  assign y_last  = y[NUM_CELLS-1];
  assign out_ovf = !((y_last[STATE_BITS-1:SAMPLE_BITS-1] == '0) ||
                     (y_last[STATE_BITS-1:SAMPLE_BITS-1] == '1));
  always_comb begin
    if (!out_ovf) begin
      sat_out = y_last[SAMPLE_BITS-1:0];
    end else if (y_last[STATE_BITS-1]) begin
      sat_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Handshake decisions
  assign accept      = in_if.valid && !busy_q;
  assign have_result = last_done_q || pend_q;
  assign load        = have_result && (!out_valid_q || out_if.ready);
  assign clip_now    = clip_q || (|clip_vec);

  // Track the word in flight and its clip flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      go_q        <= 1'b0;
      pend_q      <= 1'b0;
      clip_q      <= 1'b0;
      last_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      go_q        <= accept;
      last_done_q <= stat[NUM_CELLS-1].done;
      if (accept) begin
        busy_q <= 1'b1;
        clip_q <= 1'b0;
      end else begin
        clip_q <= clip_now;
        if (load) begin
          busy_q <= 1'b0;
        end
      end
      pend_q <= have_result && !load;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_if.sample_in;
    end
    if (load) begin
      out_sample_q <= sat_out;
      out_clip_q   <= clip_now || out_ovf;
    end
  end

  assign in_if.ready       = !busy_q;
  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_sample_q;
  assign out_if.clipped    = out_clip_q;

endmodule

[hw/rtl/fplf_cell.sv]
// One filter cell: y = round(c1*u) - round(c2*v) + off, saturated to the state range.
`timescale 1ns / 1ps

module fplf_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  fplf_pkg::coef_t     c1_i,
  input  fplf_pkg::state_t    u_i,
  input  fplf_pkg::coef_t     c2_i,
  input  fplf_pkg::state_t    v_i,
  input  fplf_pkg::state_t    off_i,
  output fplf_pkg::state_t    y_o,
  output fplf_pkg::cell_stat_t stat_o
);
  import fplf_pkg::*;

  cell_state_e state_q, state_d;
  coef_t       mul_a;
  state_t      mul_b;
  prod_t       prod_q, prod_d;
  rnd_t        first_q, first_d;
  state_t      y_q, y_d;
  sum_t        sum;
  logic        ovf;
  logic        done, clip;

  // Share one multiplier: own-state term on go, input term in the next cycle,
  // once the left neighbor's output has settled
  always_comb begin
    if (state_q == CELL_IDLE) begin
      mul_a = c2_i;
      mul_b = v_i;
    end else begin
      mul_a = c1_i;
      mul_b = u_i;
    end
    prod_d = mul_a * mul_b;
  end

  // Combine both rounded terms and the offset
  always_comb begin
    sum = sum_t'(round_prod(prod_q)) - sum_t'(first_q) + sum_t'(off_i);
    ovf = !((sum[SUM_BITS-1:STATE_BITS-1] == '0) || (sum[SUM_BITS-1:STATE_BITS-1] == '1));
  end

  // Sequence the three phases
  always_comb begin
    state_d = state_q;
    first_d = first_q;
    y_d     = y_q;
    done    = 1'b0;
    clip    = 1'b0;
    case (state_q)
      CELL_IDLE: begin
        if (go_i) begin
          state_d = CELL_SECOND;
        end
      end
      CELL_SECOND: begin
        first_d = round_prod(prod_q);
        state_d = CELL_SUM;
      end
      CELL_SUM: begin
        done = 1'b1;
        clip = ovf;
        if (!ovf) begin
          y_d = state_t'(sum);
        end else if (sum[SUM_BITS-1]) begin
          y_d = {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
          y_d = {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        state_d = CELL_IDLE;
      end
      default: begin
        state_d = CELL_IDLE;
      end
    endcase
  end

  // Hold phase and cell output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CELL_IDLE;
      y_q     <= '0;
    end else begin
      state_q <= state_d;
      y_q     <= y_d;
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    first_q <= first_d;
  end

  assign y_o         = y_q;
  assign stat_o.done = done;
  assign stat_o.clip = clip;

endmodule
